/* hw/rtl/fce_pkg.sv */
// ----------------------------------------------------------------------------
// FIR convolution package
// Shared widths, types and helper functions of the edge-clamped FIR block.
// ----------------------------------------------------------------------------
`default_nettype none

package fce_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_TAPS     = 7;
  localparam int COEF_WIDTH   = 18;
  localparam int FRAC_BITS    = 16;
  localparam int TAP_W        = $clog2(MAX_TAPS + 1);
  localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH    = PROD_WIDTH + 4;
  localparam int QUO_WIDTH    = ACC_WIDTH - FRAC_BITS;

  localparam int JOBQ_DEPTH   = 4;
  localparam int JQ_AW        = $clog2(JOBQ_DEPTH);
  localparam int JQ_CW        = $clog2(JOBQ_DEPTH + 1);
  localparam int OUTQ_DEPTH   = 8;
  localparam int OQ_AW        = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW        = $clog2(OUTQ_DEPTH + 1);

  localparam int REG_W        = 3;
  localparam int DATA_W       = COEF_WIDTH;

  localparam logic [REG_W-1:0] REG_TAP_COUNT = REG_W'(0);
  localparam logic [REG_W-1:0] REG_COEF_0    = REG_W'(1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;

  typedef struct packed {
    sample_t [MAX_TAPS-1:0] win;
    logic [TAP_W-1:0]       n;
    logic                   last;
  } job_t;

  typedef struct packed {
    logic [TAP_W-1:0]      taps;
    coef_t [MAX_TAPS-1:0]  coef;
  } cfg_t;

  typedef struct packed {
    sample_t value;
    logic    last;
  } res_t;

  function automatic logic [TAP_W-1:0] taps_eff(input logic [TAP_W-1:0] t);
    logic [TAP_W-1:0] r;
    r = t;
    if (t == '0) begin
      r = TAP_W'(1);
    end else if (t > TAP_W'(MAX_TAPS)) begin
      r = TAP_W'(MAX_TAPS);
    end
    return r;
  endfunction

  function automatic logic [TAP_W-1:0] right_of(input logic [TAP_W-1:0] t);
    return t - TAP_W'(1) - (t >> 1);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/fce_front.sv */
// ----------------------------------------------------------------------------
// FIR front end
// Accepts samples, keeps the sample window and count, and queues one job for
// every sample that releases results.
// ----------------------------------------------------------------------------
`default_nettype none

module fce_front import fce_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire sample_t          sample_in,
  input  wire logic             is_last,
  input  wire logic [TAP_W-1:0] taps,
  output logic                  job_valid,
  output job_t                  job,
  input  wire logic             job_pop
);

  sample_t [MAX_TAPS-1:0] win;
  sample_t [MAX_TAPS-1:0] win_next;
  logic [TAP_W-1:0]       seen;
  logic [TAP_W-1:0]       n_next;
  logic [TAP_W-1:0]       right;
  logic                   accept;
  logic                   produce;

  job_t                   q [JOBQ_DEPTH];
  logic [JQ_AW-1:0]       wr_ptr;
  logic [JQ_AW-1:0]       rd_ptr;
  logic [JQ_CW-1:0]       count;
  logic                   q_push;
  logic                   q_pop;

  assign full      = (count == JQ_CW'(JOBQ_DEPTH));
  assign accept    = push & ~full;
  assign win_next  = {win[MAX_TAPS-2:0], sample_in};
  assign n_next    = (seen == TAP_W'(MAX_TAPS)) ? seen : seen + TAP_W'(1);
  assign right     = right_of(taps);
  assign produce   = is_last | (n_next >= right + TAP_W'(1));
  assign q_push    = accept & produce;
  assign q_pop     = job_pop & (count != '0);
  assign job_valid = (count != '0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
    if (q_push) begin
      q[wr_ptr] <= '{win: win_next, n: n_next, last: is_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        seen <= is_last ? '0 : n_next;
      end
      if (q_push) begin
        wr_ptr <= wr_ptr + JQ_AW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + JQ_AW'(1);
      end
      if (q_push && !q_pop) begin
        count <= count + JQ_CW'(1);
      end else if (!q_push && q_pop) begin
        count <= count - JQ_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fce_back.sv */
// ----------------------------------------------------------------------------
// FIR back end
// Expands each job into one or more output positions, selects the clamped
// samples and runs the multiply and adder tree pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module fce_back import fce_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cfg_t             cfg,
  input  wire logic             job_valid,
  input  wire job_t             job,
  output logic                  job_pop,
  input  wire logic [OQ_CW-1:0] outq_count,
  output logic                  res_valid,
  output res_t                  res
);

  logic [TAP_W-1:0]       taps;
  logic [TAP_W-1:0]       left;
  logic [TAP_W-1:0]       right;
  logic [TAP_W-1:0]       nm1;
  logic [TAP_W-1:0]       d_start;
  logic [TAP_W-1:0]       d_cur;
  logic [TAP_W-1:0]       d_cnt;
  logic                   active;
  logic                   issue;
  logic                   done;
  logic [OQ_CW:0]         used;
  sample_t [MAX_TAPS-1:0] sel;
  coef_t [MAX_TAPS-1:0]   coef_eff;

  logic                   va, vb, vc, vd;
  logic                   la, lb, lc, ld;
  sample_t [MAX_TAPS-1:0] sa_smp;
  prod_t [MAX_TAPS-1:0]   sb_prod;
  acc_t [3:0]             sc_sum;
  acc_t                   sd_total;
  logic signed [QUO_WIDTH-1:0] quo;

  assign taps    = taps_eff(cfg.taps);
  assign left    = taps >> 1;
  assign right   = right_of(taps);
  assign nm1     = job.n - TAP_W'(1);
  assign d_start = (job.last && nm1 < right) ? nm1 : right;
  assign d_cur   = active ? d_cnt : d_start;
  assign used    = (OQ_CW + 1)'(outq_count) + (OQ_CW + 1)'(va) + (OQ_CW + 1)'(vb)
                 + (OQ_CW + 1)'(vc) + (OQ_CW + 1)'(vd);
  assign issue   = job_valid && (used < (OQ_CW + 1)'(OUTQ_DEPTH));
  assign done    = !job.last || (d_cur == '0);
  assign job_pop = issue && done;

  always_comb begin
    logic signed [TAP_W+1:0] k;
    logic signed [TAP_W+1:0] lim;
    lim = (TAP_W + 2)'(nm1);
    for (int j = 0; j < MAX_TAPS; j++) begin
      k = (TAP_W + 2)'(d_cur) + (TAP_W + 2)'(left) - (TAP_W + 2)'(j);
      if (k < 0) begin
        sel[j] = job.win[0];
      end else if (k > lim) begin
        sel[j] = job.win[nm1];
      end else begin
        sel[j] = job.win[k[TAP_W-1:0]];
      end
      coef_eff[j] = (TAP_W'(j) < taps) ? cfg.coef[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      d_cnt  <= '0;
    end else if (issue) begin
      if (done) begin
        active <= 1'b0;
      end else begin
        active <= 1'b1;
        d_cnt  <= d_cur - TAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= issue;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    sa_smp <= sel;
    la     <= job.last && (d_cur == '0);
    for (int j = 0; j < MAX_TAPS; j++) begin
      sb_prod[j] <= sa_smp[j] * coef_eff[j];
    end
    lb <= la;
    sc_sum[0] <= ACC_WIDTH'(sb_prod[0]) + ACC_WIDTH'(sb_prod[1]);
    sc_sum[1] <= ACC_WIDTH'(sb_prod[2]) + ACC_WIDTH'(sb_prod[3]);
    sc_sum[2] <= ACC_WIDTH'(sb_prod[4]) + ACC_WIDTH'(sb_prod[5]);
    sc_sum[3] <= ACC_WIDTH'(sb_prod[6]) + (ACC_WIDTH'(1) <<< (FRAC_BITS - 1));
    lc <= lb;
    sd_total <= (sc_sum[0] + sc_sum[1]) + (sc_sum[2] + sc_sum[3]);
    ld <= lc;
  end

  assign quo = sd_total[ACC_WIDTH-1:FRAC_BITS];

  always_comb begin
    if (quo > QUO_WIDTH'(sample_t'({1'b0, {(SAMPLE_WIDTH - 1){1'b1}}}))) begin
      res.value = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    end else if (quo < QUO_WIDTH'(sample_t'({1'b1, {(SAMPLE_WIDTH - 1){1'b0}}}))) begin
      res.value = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    end else begin
      res.value = quo[SAMPLE_WIDTH-1:0];
    end
    res.last = ld;
  end

  assign res_valid = vd;

endmodule

`default_nettype wire

/* hw/rtl/fce_outq.sv */
// ----------------------------------------------------------------------------
// FIR result queue
// Holds finished results until the consumer takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module fce_outq import fce_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr,
  input  wire res_t        wr_res,
  input  wire logic        pop,
  output logic             empty,
  output res_t             head,
  output logic [OQ_CW-1:0] count
);

  res_t             mem [OUTQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic             rd;

  assign empty = (count == '0);
  assign rd    = pop & ~empty;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + OQ_AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      if (wr && !rd) begin
        count <= count + OQ_CW'(1);
      end else if (!wr && rd) begin
        count <= count - OQ_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fir_convolution_edge_clamp_unit.sv */
// ----------------------------------------------------------------------------
// FIR convolution with replicated border
// Up to seven Q2.16 taps over a stream of signed 16-bit samples.
// ----------------------------------------------------------------------------
// The unit takes one sample per clock cycle while full is low. Each sample
// is recorded in the sample window and, if it releases results, it is queued
// as one job for the back end, which issues one output position per cycle;
// a sample marked last therefore occupies the back end for one issue per
// result that it flushes, one to four in all. Each issued position passes
// through sample selection, multiply, two adder levels, rounding and
// saturation on its way to the output queue; with a job waiting, issue pauses
// only when the eight-entry result queue and the pipeline together are full.
`default_nettype none

module fir_convolution_edge_clamp_unit import fce_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [15:0]       sample_in,
  input  wire logic              is_last,
  output logic                   empty,
  input  wire logic              pop,
  output logic [15:0]            sample_out,
  output logic                   last_out,
  input  wire logic              wr_en,
  input  wire logic [REG_W-1:0]  wr_index,
  input  wire logic [DATA_W-1:0] wr_data
);

  cfg_t             cfg;
  logic             job_valid;
  job_t             job;
  logic             job_pop;
  logic [OQ_CW-1:0] outq_count;
  logic             res_valid;
  res_t             res;
  res_t             head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.taps <= TAP_W'(1);
      for (int i = 0; i < MAX_TAPS; i++) begin
        cfg.coef[i] <= (i == 0) ? COEF_WIDTH'(1 << FRAC_BITS) : '0;
      end
    end else if (wr_en) begin
      if (wr_index == REG_TAP_COUNT) begin
        cfg.taps <= wr_data[TAP_W-1:0];
      end else begin
        cfg.coef[wr_index - REG_COEF_0] <= wr_data;
      end
    end
  end

  fce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .sample_in (sample_in),
    .is_last   (is_last),
    .taps      (taps_eff(cfg.taps)),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  fce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop),
    .outq_count (outq_count),
    .res_valid  (res_valid),
    .res        (res)
  );

  fce_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_valid),
    .wr_res (res),
    .pop    (pop),
    .empty  (empty),
    .head   (head),
    .count  (outq_count)
  );

  assign sample_out = head.value;
  assign last_out   = head.last;

endmodule

`default_nettype wire

/* dv/fce_result_checker.sv */
// ----------------------------------------------------------------------------
// FIR convolution result checker
// Follows register writes and sample transfers, predicts each filtered
// sample and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fce_result_checker import fce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic [15:0]       sample_in,
  input  logic              is_last,
  input  logic              empty,
  input  logic              pop,
  input  logic [15:0]       sample_out,
  input  logic              last_out,
  input  logic              wr_en,
  input  logic [REG_W-1:0]  wr_index,
  input  logic [DATA_W-1:0] wr_data,
  output int                failures,
  output int                pending
);

  logic [2:0] tap_reg;
  coef_t      coef_reg [MAX_TAPS];
  sample_t    window [MAX_TAPS];
  int         seen;
  res_t       expected_q [$];
  int         shown;

  task automatic report_mismatch(input string what);
    if (shown < 40) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
    shown++;
    failures++;
  endtask

  // Filtered value at the position d samples older than the newest one.
  function automatic sample_t filter_point(input int d, input int taps, input int n);
    longint acc;
    longint q;
    int     k;
    acc = 0;
    for (int j = 0; j < taps; j++) begin
      k = d + taps / 2 - j;
      if (k < 0) k = 0;
      if (k > n - 1) k = n - 1;
      if (k > MAX_TAPS - 1) k = MAX_TAPS - 1;
      acc += longint'(window[k]) * longint'(coef_reg[j]);
    end
    q = (acc + 32768) >>> 16;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return sample_t'(q);
  endfunction

  task automatic take_sample(input sample_t s, input logic l);
    int   taps;
    int   right;
    int   d;
    res_t r;
    taps  = (tap_reg == 3'd0) ? 1 : int'(tap_reg);
    right = taps - 1 - taps / 2;
    for (int i = MAX_TAPS - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = s;
    if (seen < MAX_TAPS) seen++;
    if (!l) begin
      if (seen >= right + 1) begin
        r.value = filter_point(right, taps, seen);
        r.last  = 1'b0;
        expected_q.push_back(r);
      end
    end else begin
      d = (seen - 1 < right) ? seen - 1 : right;
      while (d >= 0) begin
        r.value = filter_point(d, taps, seen);
        r.last  = (d == 0);
        expected_q.push_back(r);
        d--;
      end
      foreach (window[i]) window[i] = '0;
      seen = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      tap_reg = 3'd1;
      foreach (coef_reg[i]) coef_reg[i] = '0;
      coef_reg[0] = coef_t'(65536);
      foreach (window[i]) window[i] = '0;
      seen = 0;
      expected_q.delete();
      failures = 0;
      shown = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result transfer %0d/%0b with nothing expected",
                                    $signed(sample_out), last_out));
        end else begin
          want = expected_q.pop_front();
          if (sample_out !== want.value) begin
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      $signed(sample_out), want.value));
          end
          if (last_out !== want.last) begin
            report_mismatch($sformatf("last_out %b, expected %b", last_out, want.last));
          end
        end
      end
      if (wr_en) begin
        if (wr_index == REG_TAP_COUNT) begin
          tap_reg = wr_data[2:0];
        end else begin
          coef_reg[wr_index - REG_COEF_0] = coef_t'(wr_data);
        end
      end
      if (push && !full) begin
        take_sample(sample_t'(sample_in), is_last);
      end
    end
    pending = expected_q.size();
  end

endmodule

/* dv/fir_convolution_edge_clamp_unit_test.sv */
// ----------------------------------------------------------------------------
// FIR convolution unit testbench
// Drives directed and random sample sequences through the edge-clamped FIR
// unit under several filter settings and handshake patterns, and reports the
// verdict of the result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fir_convolution_edge_clamp_unit_test;
  import fce_pkg::*;

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [15:0]       sample_in;
  logic              is_last;
  logic              empty;
  logic              pop;
  logic [15:0]       sample_out;
  logic              last_out;
  logic              wr_en;
  logic [REG_W-1:0]  wr_index;
  logic [DATA_W-1:0] wr_data;

  int    failures;
  int    pending;
  int    feed_idle_pct = 0;
  int    drain_stall_pct = 0;
  int    hold_left = 0;
  coef_t coef_plan [MAX_TAPS];

  fir_convolution_edge_clamp_unit dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_in  (sample_in),
    .is_last    (is_last),
    .empty      (empty),
    .pop        (pop),
    .sample_out (sample_out),
    .last_out   (last_out),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  fce_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_in  (sample_in),
    .is_last    (is_last),
    .empty      (empty),
    .pop        (pop),
    .sample_out (sample_out),
    .last_out   (last_out),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver may be held off for a counted stretch to fill the unit.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= drain_stall_pct);
      end
    end
  end

  task automatic feed(input sample_t s, input logic l);
    while ($urandom_range(99) < feed_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    sample_in <= s;
    is_last   <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(negedge clk);
  endtask

  task automatic program_filter(input logic [DATA_W-1:0] tap_word);
    write_reg(REG_TAP_COUNT, tap_word);
    for (int i = 0; i < MAX_TAPS; i++) begin
      write_reg(REG_W'(REG_COEF_0 + i), DATA_W'(coef_plan[i]));
    end
    wr_en <= 1'b0;
  endtask

  function automatic coef_t random_coef();
    case ($urandom_range(0, 4))
      0: return coef_t'($urandom);
      1: return $urandom_range(0, 1) ? coef_t'(131071) : coef_t'(-131072);
      2: return '0;
      default: return coef_t'(int'($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 3))
      0: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      1: return $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int items, input int idle, input int stall, input int hold);
    int left;
    int len;
    logic noisy;
    feed_idle_pct   = idle;
    drain_stall_pct = stall;
    foreach (coef_plan[i]) coef_plan[i] = random_coef();
    program_filter(DATA_W'($urandom));
    hold_left = hold;
    left = items;
    while (left > 0) begin
      noisy = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 9))
        0, 1: len = $urandom_range(1, 3);
        2:    len = $urandom_range(11, 30);
        default: len = $urandom_range(4, 10);
      endcase
      for (int i = 0; i < len && left > 0; i++) begin
        feed(random_sample(), (i == len - 1) || (left == 1) ||
                              (noisy && $urandom_range(0, 2) == 0));
        left--;
      end
    end
    settle();
  endtask

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    sample_in = '0;
    is_last   = 1'b0;
    wr_en     = 1'b0;
    wr_index  = '0;
    wr_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // After reset a single unity tap passes samples straight through.
    feed(sample_t'(32767), 1'b0);
    feed(sample_t'(-32768), 1'b0);
    feed(sample_t'(1), 1'b1);
    settle();

    // Seven maximal taps: saturation, a short sequence and a lone sample.
    foreach (coef_plan[i]) coef_plan[i] = coef_t'(131071);
    program_filter(DATA_W'(7));
    feed(sample_t'(32767), 1'b0);
    feed(sample_t'(32767), 1'b0);
    feed(sample_t'(-32768), 1'b1);
    feed(sample_t'(-32768), 1'b1);
    settle();

    // A tap count of zero behaves as one tap; the unused taps must not count.
    coef_plan[0] = coef_t'(-131072);
    program_filter(18'h3fff8);
    feed(sample_t'(32767), 1'b0);
    feed(sample_t'(-32768), 1'b1);
    settle();

    // Even tap count with mixed weights.
    foreach (coef_plan[i]) coef_plan[i] = '0;
    coef_plan[0] = coef_t'(32768);
    coef_plan[1] = coef_t'(-32768);
    coef_plan[2] = coef_t'(65536);
    coef_plan[3] = coef_t'(16384);
    program_filter(DATA_W'(4));
    feed(sample_t'(1), 1'b0);
    feed(sample_t'(-1), 1'b0);
    feed(sample_t'(0), 1'b0);
    feed(sample_t'(5), 1'b0);
    feed(sample_t'(-3), 1'b1);
    settle();

    // Half weight on the current sample: ties round towards plus infinity.
    foreach (coef_plan[i]) coef_plan[i] = '0;
    coef_plan[1] = coef_t'(32768);
    program_filter(DATA_W'(2));
    feed(sample_t'(1), 1'b0);
    feed(sample_t'(-1), 1'b0);
    feed(sample_t'(3), 1'b0);
    feed(sample_t'(-3), 1'b1);
    settle();

    run_phase(40, 0, 0, 0);
    run_phase(40, 0, 0, 90);
    run_phase(40, 87, 0, 0);
    run_phase(40, 0, 87, 0);
    run_phase(40, 11, 11, 0);
    run_phase(40, 87, 0, 0);
    run_phase(30, 0, 87, 0);
    run_phase(40, 11, 11, 0);

    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/fce_pkg.sv
hw/rtl/fce_front.sv
hw/rtl/fce_back.sv
hw/rtl/fce_outq.sv
hw/rtl/fir_convolution_edge_clamp_unit.sv
dv/fce_result_checker.sv
dv/fir_convolution_edge_clamp_unit_test.sv
